// ===== sv/pba_pkg.sv =====
// Shared types, codes and defaults for the pool block allocator.
`default_nettype none
package pba_pkg;

   localparam int MAX_BLOCKS_DEF = 1024;
   localparam int ADDR_WIDTH_DEF = 32;

   localparam int DATA_W = 32;

   // request opcodes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
   localparam logic [1:0] ST_STACK_FULL = 2'd2;

   // csr indexes
   localparam logic [1:0] CSR_REGION_BASE = 2'd0;
   localparam logic [1:0] CSR_REGION_SIZE = 2'd1;
   localparam logic [1:0] CSR_BLOCK_SIZE  = 2'd2;
   localparam logic [1:0] CSR_BLOCK_ALIGN = 2'd3;

   localparam logic [15:0] BLOCK_SIZE_RST  = 16'd8;
   localparam logic [7:0]  BLOCK_ALIGN_RST = 8'd8;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stk_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stk_stat_type;

   typedef struct packed {
      logic [DATA_W-1:0] block_address;
      logic [1:0]        status;
      logic [DATA_W-1:0] bytes_in_use;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/pool_block_allocator.sv =====
// Usage: a fixed-size block pool allocator with a LIFO free list.
//
// Request channel (req_valid/req_ready): req_opcode selects allocate, free
// or clear; req_release_address carries the block returned by free.
// Response channel (rsp_valid/rsp_ready): one response per request with
// rsp_block_address, rsp_status and rsp_bytes_in_use after the operation.
// CSR port: csr_wr_en writes csr_wr_data into register csr_index at once;
// write only while no request is in flight.
//
// Each response is registered in the output register, or in the skid
// entry while the receiver stalls. Throughput is one request per cycle
// while req_ready is high; the freed-stack memory is read ahead every
// cycle so a pop is served from the cached top. A two-entry response
// buffer lets one more request in while the receiver stalls; req_ready
// drops only when both entries are held. Reset empties the free stack,
// zeroes the bump offset and used bytes, and loads the CSR defaults. No
// memory clearing pass is needed: requests are taken once reset ends.
`default_nettype none
module pool_block_allocator #(
   parameter int MAX_BLOCKS = pba_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_WIDTH = pba_pkg::ADDR_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_release_address,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_block_address,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_bytes_in_use,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);
   import pba_pkg::*;

   localparam logic [DATA_W-1:0] ADDR_MASK =
      (ADDR_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << ADDR_WIDTH) - 64'd1);

   // csr registers
   logic [31:0] region_base_ff, region_size_ff;
   logic [15:0] block_size_ff;
   logic [7:0]  block_align_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         region_size_ff <= '0;
         block_size_ff  <= BLOCK_SIZE_RST;
         block_align_ff <= BLOCK_ALIGN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_REGION_BASE: region_base_ff <= csr_wr_data;
            CSR_REGION_SIZE: region_size_ff <= csr_wr_data;
            CSR_BLOCK_SIZE:  block_size_ff  <= csr_wr_data[15:0];
            CSR_BLOCK_ALIGN: block_align_ff <= csr_wr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // allocator state
   logic [31:0]  offset_ff, offset_in;
   logic [31:0]  used_ff, used_in;
   stk_ctrl_type stk_ctrl;
   stk_stat_type stk_stat;
   logic [31:0]  stk_top;
   rsp_type      res;

   logic        accept;
   logic [31:0] bsize;
   logic [32:0] fresh_end;
   logic        fresh_ok;
   logic [7:0]  align_mask;
   logic [31:0] align_adj;

   assign accept     = req_valid && req_ready;
   assign bsize      = {16'd0, block_size_ff};
   assign fresh_end  = {1'b0, offset_ff} + {1'b0, bsize};
   assign fresh_ok   = (block_size_ff != '0) && (fresh_end <= {1'b0, region_size_ff});
   // an alignment of zero counts as one: no adjustment
   assign align_mask = (block_align_ff == '0) ? 8'd0 : block_align_ff - 8'd1;
   assign align_adj  = (32'd0 - region_base_ff) & {24'd0, align_mask};

   always_comb begin
      offset_in         = offset_ff;
      used_in           = used_ff;
      stk_ctrl          = '0;
      res.block_address = '0;
      res.status        = ST_OK;
      case (req_opcode)
         OP_ALLOC: begin
            if (!stk_stat.empty) begin
               stk_ctrl.pop      = accept;
               res.block_address = stk_top;
               used_in           = used_ff + bsize;
            end else if (fresh_ok) begin
               res.block_address = (region_base_ff + offset_ff) & ADDR_MASK;
               offset_in         = offset_ff + bsize;
               used_in           = used_ff + bsize;
            end else begin
               res.status = ST_EXHAUSTED;
            end
         end
         OP_FREE: begin
            if (stk_stat.full) begin
               res.status = ST_STACK_FULL;
            end else begin
               stk_ctrl.push = accept;
               used_in       = used_ff - bsize;
            end
         end
         OP_CLEAR: begin
            stk_ctrl.clear = accept;
            offset_in      = align_adj;
            used_in        = '0;
         end
         default: begin
         end
      endcase
      res.bytes_in_use = used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         used_ff   <= '0;
      end else if (accept) begin
         offset_ff <= offset_in;
         used_ff   <= used_in;
      end
   end

   pba_free_stack #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stk_ctrl),
      .push_data (req_release_address),
      .stat      (stk_stat),
      .top_data  (stk_top)
   );

   // two-entry response buffer: output register plus skid
   rsp_type out_ff, out_in, skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   assign req_ready = !skid_valid_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_block_address = out_ff.block_address;
   assign rsp_status        = out_ff.status;
   assign rsp_bytes_in_use  = out_ff.bytes_in_use;

endmodule
`default_nettype wire

// ===== sv/pba_free_stack.sv =====
// LIFO of freed block addresses: memory plus cached top and next-below entries.
`default_nettype none
module pba_free_stack #(
   parameter int MAX_BLOCKS = pba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pba_pkg::stk_ctrl_type     ctrl,
   input  wire logic [pba_pkg::DATA_W-1:0] push_data,
   output pba_pkg::stk_stat_type          stat,
   output logic [pba_pkg::DATA_W-1:0]     top_data
);
   import pba_pkg::*;

   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);
   localparam logic [CW-1:0] CNT_TWO = CW'(2);

   logic [DATA_W-1:0] mem [MAX_BLOCKS];

   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [DATA_W-1:0] below_ff;
   logic [CW-1:0]     below_cnt;
   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     wr_addr;

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.push) begin
         count_in = count_ff + CNT_ONE;
         top_in   = push_data;
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_ONE;
         top_in   = below_ff;
      end
   end

   // below_ff always tracks the entry under the next top
   assign below_cnt = count_in - CNT_TWO;
   assign rd_addr   = below_cnt[IW-1:0];
   assign wr_addr   = count_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.clear) begin
         mem[wr_addr] <= push_data;
      end
      below_ff <= mem[rd_addr];
      top_ff   <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_MAX);
   assign top_data   = top_ff;

endmodule
`default_nettype wire

// ===== sv/pba_checker.sv =====
// Port-level assertions for the pool block allocator, bound to the top level.
`default_nettype none
module pba_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_block_address,
   input wire logic [1:0]  rsp_status
);
   import pba_pkg::*;

   // intake only stalls while a response is waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no response pending");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_EXHAUSTED ||
                     rsp_status == ST_STACK_FULL))
      else $error("bad response status");

   a_err_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_block_address == '0)
      else $error("error response carries an address");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response buffer not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_address))
      else $error("stalled response changed");

endmodule

bind pool_block_allocator pba_checker u_pba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_block_address (rsp_block_address),
   .rsp_status        (rsp_status)
);
`default_nettype wire

// ===== dv/pool_block_allocator_test.sv =====
// Self-checking testbench for the pool block allocator: predicts every response and compares it.
`timescale 1ns / 1ps
module pool_block_allocator_test;
   import pba_pkg::*;

   localparam int STACK_DEPTH = MAX_BLOCKS_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_ALLOC;
   logic [31:0] req_release_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [31:0] rsp_block_address;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_bytes_in_use;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_REGION_BASE;
   logic [31:0] csr_wr_data = '0;

   // pool model state and register copies
   logic [31:0] rgn_base = '0;
   logic [31:0] rgn_size = '0;
   logic [15:0] blk_size = BLOCK_SIZE_RST;
   logic [7:0]  blk_align = BLOCK_ALIGN_RST;
   logic [31:0] freed_addrs [STACK_DEPTH];
   int          stack_depth = 0;
   logic [31:0] bump_offset = '0;
   logic [31:0] used_bytes = '0;

   rsp_type     grant_queue [$];
   logic [31:0] granted_addrs [$];

   int gap_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int request_count = 0;
   int response_count = 0;
   int settings_count = 0;
   int exhausted_count = 0;
   int overflow_count = 0;

   pool_block_allocator i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_release_address(req_release_address),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_block_address(rsp_block_address),
      .rsp_status(rsp_status),
      .rsp_bytes_in_use(rsp_bytes_in_use),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_type compute_grant(input logic [1:0] op, input logic [31:0] rel);
      rsp_type grant;
      logic [7:0] align_eff;
      grant = '0;
      grant.status = ST_OK;
      case (op)
         OP_ALLOC: begin
            if (stack_depth != 0) begin
               stack_depth--;
               grant.block_address = freed_addrs[stack_depth];
               used_bytes += 32'(blk_size);
            end else if (blk_size != 0 &&
                         {1'b0, bump_offset} + 33'(blk_size) <= {1'b0, rgn_size}) begin
               grant.block_address = rgn_base + bump_offset;
               bump_offset += 32'(blk_size);
               used_bytes += 32'(blk_size);
            end else begin
               grant.status = ST_EXHAUSTED;
            end
         end
         OP_FREE: begin
            if (stack_depth >= STACK_DEPTH) begin
               grant.status = ST_STACK_FULL;
            end else begin
               freed_addrs[stack_depth] = rel;
               stack_depth++;
               used_bytes -= 32'(blk_size);
            end
         end
         OP_CLEAR: begin
            // align of zero behaves as one; non power of two still used as a mask
            align_eff = (blk_align == 8'd0) ? 8'd1 : blk_align;
            stack_depth = 0;
            bump_offset = (32'd0 - rgn_base) & {24'd0, align_eff - 8'd1};
            used_bytes = '0;
         end
         default: begin
         end
      endcase
      grant.bytes_in_use = used_bytes;
      return grant;
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [31:0] addr);
      rsp_type grant;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_release_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      grant = compute_grant(op, addr);
      grant_queue.push_back(grant);
      request_count++;
      if (op == OP_ALLOC && grant.status == ST_OK) granted_addrs.push_back(grant.block_address);
      if (op == OP_CLEAR) granted_addrs.delete();
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (grant_queue.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_REGION_BASE: rgn_base = data;
         CSR_REGION_SIZE: rgn_size = data;
         CSR_BLOCK_SIZE:  blk_size = data[15:0];
         CSR_BLOCK_ALIGN: blk_align = data[7:0];
         default: ;
      endcase
   endtask

   task automatic program_pool(input logic [31:0] base, input logic [31:0] size,
                               input logic [15:0] bsize, input logic [7:0] align);
      wait_for_idle();
      csr_write(CSR_REGION_BASE, base);
      csr_write(CSR_REGION_SIZE, size);
      // upper bits of the narrow registers must be ignored
      csr_write(CSR_BLOCK_SIZE, {16'($urandom), bsize});
      csr_write(CSR_BLOCK_ALIGN, {24'($urandom), align});
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   task automatic random_request();
      int pick;
      logic [31:0] addr;
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
         send_request(OP_ALLOC, $urandom);
      end else if (pick < 88) begin
         if (granted_addrs.size() != 0 && $urandom_range(0, 2) != 0) begin
            addr = granted_addrs.pop_back();
         end else begin
            case ($urandom_range(0, 3))
               0: addr = '0;
               1: addr = '1;
               default: addr = $urandom;
            endcase
         end
         send_request(OP_FREE, addr);
      end else if (pick < 96) begin
         send_request(OP_CLEAR, $urandom);
      end else begin
         send_request(OP_UNUSED, $urandom);
      end
   endtask

   task automatic run_mix(input int count, input bit start_clear);
      if (start_clear) send_request(OP_CLEAR, $urandom);
      for (int i = 0; i < count; i++) random_request();
   endtask

   task automatic test_directed_walk();
      gap_pct = 0;
      stall_pct = 0;
      // reset config has an empty region
      send_request(OP_ALLOC, '0);
      program_pool(32'h0000_1003, 32'd64, 16'd8, 8'd8);
      send_request(OP_CLEAR, '1);
      // seven blocks fit after the alignment skip, the eighth does not
      repeat (8) send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 32'hFFFF_FFFF);
      send_request(OP_FREE, 32'h0000_0000);
      repeat (3) send_request(OP_ALLOC, '0);
      send_request(OP_UNUSED, 32'h5A5A_A5A5);
      // free with nothing allocated wraps used bytes below zero
      send_request(OP_CLEAR, '0);
      send_request(OP_FREE, 32'h1234_5678);
      send_request(OP_ALLOC, '1);
   endtask

   task automatic test_register_sweep();
      gap_pct = 30;
      stall_pct = 30;
      // base near the top: first block address wraps to zero
      program_pool(32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF, 8'd128);
      run_mix(45, 1);
      gap_pct = 0;
      stall_pct = 0;
      program_pool(32'h0, 32'h0, 16'd1, 8'd1);
      run_mix(30, 1);
      gap_pct = 50;
      stall_pct = 10;
      // region smaller than the alignment skip
      program_pool(32'h7, 32'd4, 16'd8, 8'd16);
      run_mix(30, 1);
      // zero block size with zero alignment
      program_pool($urandom, 32'd200, 16'd0, 8'd0);
      run_mix(40, 1);
      gap_pct = 20;
      stall_pct = 50;
      program_pool(32'h101, 32'd1000, 16'd24, 8'd3);
      run_mix(45, 1);
      // new registers without a clear: bump offset carries over
      program_pool(32'h100, 32'd2000, 16'd40, 8'd255);
      run_mix(45, 0);
      program_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 8'd255);
      run_mix(45, 1);
      repeat (2) begin
         gap_pct = $urandom_range(0, 40);
         stall_pct = $urandom_range(0, 40);
         program_pool($urandom, $urandom_range(0, 4096), 16'($urandom_range(1, 64)),
                      8'(1 << $urandom_range(0, 7)));
         run_mix(60, 1);
      end
   endtask

   task automatic test_stack_overflow();
      gap_pct = 10;
      stall_pct = 20;
      program_pool(32'h2000_0000, 32'h0001_0000, 16'd64, 8'd64);
      send_request(OP_CLEAR, '0);
      // one more free than the stack holds
      repeat (STACK_DEPTH + 1) send_request(OP_FREE, $urandom);
      repeat (12) send_request(OP_ALLOC, '0);
      send_request(OP_FREE, '1);
      send_request(OP_CLEAR, '0);
   endtask

   task automatic test_back_to_back();
      gap_pct = 0;
      stall_pct = 0;
      program_pool(32'h0000_4000, 32'd512, 16'd16, 8'd32);
      run_mix(60, 1);
   endtask

   // receiver side stalls
   initial begin
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         if (rsp_status == ST_EXHAUSTED) exhausted_count++;
         if (rsp_status == ST_STACK_FULL) overflow_count++;
         if (grant_queue.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = grant_queue.pop_front();
            if (rsp_block_address !== want.block_address) begin
               $error("block_address: expected %h, got %h", want.block_address,
                      rsp_block_address);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_bytes_in_use !== want.bytes_in_use) begin
               $error("bytes_in_use: expected %h, got %h", want.bytes_in_use,
                      rsp_bytes_in_use);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("pool_block_allocator: mismatch");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_walk();
      test_register_sweep();
      test_stack_overflow();
      test_back_to_back();
      wait_for_idle();
      if (grant_queue.size() != 0) begin
         $error("%0d responses never arrived", grant_queue.size());
         error_count++;
      end
      $display("%0d requests, %0d responses over %0d register settings",
               request_count, response_count, settings_count);
      $display("%0d exhausted allocations, %0d dropped frees on a full stack",
               exhausted_count, overflow_count);
      if (error_count == 0)
         $display("pool_block_allocator: match");
      else
         $display("pool_block_allocator: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pba_pkg.sv
sv/pba_free_stack.sv
sv/pool_block_allocator.sv
sv/pba_checker.sv
dv/pool_block_allocator_test.sv
